// ----- hdl/fdf_pkg.sv -----
package fdf_pkg;

  // Frame layout
  localparam logic [7:0] StartMark = 8'h2a;
  localparam int unsigned HdrBytes = 6;
  localparam int unsigned HdrCntW = 3;
  localparam logic [HdrCntW-1:0] HdrLast = HdrCntW'(HdrBytes - 1);

  // Header byte positions
  localparam logic [HdrCntW-1:0] HdrMark    = 3'd0;
  localparam logic [HdrCntW-1:0] HdrChan    = 3'd1;
  localparam logic [HdrCntW-1:0] HdrSeqHi   = 3'd2;
  localparam logic [HdrCntW-1:0] HdrSeqLo   = 3'd3;
  localparam logic [HdrCntW-1:0] HdrLenHi   = 3'd4;

  // Tag carried with every result item
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_BAD_MARK = 2'd2
  } kind_e;

endpackage

// ----- hdl/fdf_if.sv -----
// Input channel: one received byte per item
interface fdf_in_if;
  import fdf_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Output channel: one tagged byte per item
interface fdf_out_if;
  import fdf_pkg::*;

  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  byte_out;
  logic [7:0]  channel;
  logic [15:0] sequence_res;
  logic [15:0] payload_length;
  logic        frame_end;

  modport source (
    output valid, output kind, output byte_out, output channel,
    output sequence_res, output payload_length, output frame_end,
    input ready
  );
  modport sink (
    input valid, input kind, input byte_out, input channel,
    input sequence_res, input payload_length, input frame_end,
    output ready
  );
endinterface

// ----- hdl/flap_frame_deframer_core.sv -----
// Receive deframer: takes one byte per item and returns one tagged item per byte
// (header byte, payload byte or bad start marker) along with the channel,
// sequence number and payload length captured from the current six-byte header,
// and a frame_end flag on the byte that completes a frame (the sixth header byte
// when the length is zero). Items pass through two register stages, an input
// register and a result register; the block sustains one byte per cycle while
// the output is not stalled, and a stalled output holds the pipeline without
// dropping or repeating anything.
module flap_frame_deframer_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  fdf_in_if.sink           in_i,
  fdf_out_if.source        out_o
);
  import fdf_pkg::*;

  // Pipeline control
  logic in_vld_q;
  logic [7:0] in_byte_q;
  logic out_vld_q;
  logic out_adv;
  logic in_adv;

  // Frame state
  logic               phase_q, phase_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [7:0]         chan_q, chan_d;
  logic [15:0]        seq_q, seq_d;
  logic [15:0]        len_q, len_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        rem_dec;
  kind_e              kind_d;
  logic               end_d;

  // Result register
  kind_e       kind_q;
  logic [7:0]  byte_q;
  logic [7:0]  chan_out_q;
  logic [15:0] seq_out_q;
  logic [15:0] len_out_q;
  logic        end_q;

  assign out_adv    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_adv     = !in_vld_q || out_adv;
  assign in_i.ready = in_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_i.valid) begin
      in_byte_q <= in_i.rx_byte;
    end
  end

  // Next frame state for the byte in the input register
  assign rem_dec = rem_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    chan_d    = chan_q;
    seq_d     = seq_q;
    len_d     = len_q;
    rem_d     = rem_q;
    kind_d    = KIND_HEADER;
    end_d     = 1'b0;
    if (phase_q) begin
      kind_d = KIND_PAYLOAD;
      rem_d  = rem_dec;
      if (rem_dec == 16'd0) begin
        end_d     = 1'b1;
        phase_d   = 1'b0;
        hdr_cnt_d = HdrMark;
      end
    end else begin
      unique case (hdr_cnt_q)
        HdrMark: begin
          if (in_byte_q != StartMark) begin
            kind_d = KIND_BAD_MARK;
          end else begin
            chan_d    = 8'd0;
            seq_d     = 16'd0;
            len_d     = 16'd0;
            hdr_cnt_d = HdrChan;
          end
        end
        HdrChan: begin
          chan_d    = in_byte_q;
          hdr_cnt_d = HdrSeqHi;
        end
        HdrSeqHi: begin
          seq_d     = {in_byte_q, 8'd0};
          hdr_cnt_d = HdrSeqLo;
        end
        HdrSeqLo: begin
          seq_d     = {seq_q[15:8], in_byte_q};
          hdr_cnt_d = HdrLenHi;
        end
        HdrLenHi: begin
          len_d     = {in_byte_q, 8'd0};
          hdr_cnt_d = HdrLast;
        end
        default: begin
          // last header byte: low half of the length
          len_d     = {len_q[15:8], in_byte_q};
          hdr_cnt_d = HdrMark;
          rem_d     = len_d;
          if (len_d == 16'd0) begin
            end_d = 1'b1;
          end else begin
            phase_d = 1'b1;
          end
        end
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      hdr_cnt_q <= HdrMark;
      chan_q    <= 8'd0;
      seq_q     <= 16'd0;
      len_q     <= 16'd0;
      rem_q     <= 16'd0;
    end else if (out_adv) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      chan_q    <= chan_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      kind_q     <= kind_d;
      byte_q     <= in_byte_q;
      chan_out_q <= chan_d;
      seq_out_q  <= seq_d;
      len_out_q  <= len_d;
      end_q      <= end_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.kind           = kind_q;
  assign out_o.byte_out       = byte_q;
  assign out_o.channel        = chan_out_q;
  assign out_o.sequence_res   = seq_out_q;
  assign out_o.payload_length = len_out_q;
  assign out_o.frame_end      = end_q;

`ifndef SYNTHESIS
  // Header count is idle while payload bytes flow
  a_phase_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (hdr_cnt_q == HdrMark))
    else $error("header count nonzero in payload phase");

  // Header count never passes the last header byte
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= HdrLast)
    else $error("header count out of range");

  // Payload phase always has bytes left
  a_rem_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (rem_q != 16'd0))
    else $error("payload phase with nothing remaining");

  // A frame ending on a header byte must have zero length
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && end_q && (kind_q == KIND_HEADER)) |-> (len_out_q == 16'd0))
    else $error("header frame end with nonzero length");

  // Bad marker never ends a frame
  a_bad_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (kind_q == KIND_BAD_MARK)) |-> !end_q)
    else $error("bad marker flagged as frame end");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import fdf_pkg::*;

  // Expected tag for one received byte
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  chan;
    logic [15:0] seq;
    logic [15:0] len;
    logic        last;
  } byte_tag_t;

  logic clk_i;
  logic rst_ni;

  fdf_in_if  rx_if ();
  fdf_out_if tag_if ();

  flap_frame_deframer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rx_if),
    .out_o  (tag_if)
  );

  // Deframer state as predicted
  logic        in_payload;
  logic [2:0]  hdr_count;
  logic [7:0]  chan_q;
  logic [15:0] seq_q;
  logic [15:0] len_q;
  logic [15:0] bytes_left;

  byte_tag_t   pending_tags[$];
  int unsigned bytes_sent;
  int unsigned mismatches;
  bit          no_stalls;

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Works out the tag of one byte and advances the predicted state
  function automatic byte_tag_t deframe_byte(input logic [7:0] b);
    byte_tag_t t;
    t.kind = KIND_HEADER;
    t.last = 1'b0;
    if (in_payload) begin
      t.kind = KIND_PAYLOAD;
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
        t.last     = 1'b1;
        in_payload = 1'b0;
        hdr_count  = HdrMark;
      end
    end else begin
      case (hdr_count)
        HdrMark: begin
          if (b != StartMark) begin
            t.kind = KIND_BAD_MARK;
          end else begin
            chan_q    = '0;
            seq_q     = '0;
            len_q     = '0;
            hdr_count = HdrChan;
          end
        end
        HdrChan: begin
          chan_q    = b;
          hdr_count = HdrSeqHi;
        end
        HdrSeqHi: begin
          seq_q     = {b, 8'h00};
          hdr_count = HdrSeqLo;
        end
        HdrSeqLo: begin
          seq_q[7:0] = b;
          hdr_count  = HdrLenHi;
        end
        HdrLenHi: begin
          len_q     = {b, 8'h00};
          hdr_count = HdrLast;
        end
        default: begin
          // last header byte: low half of the length
          len_q[7:0] = b;
          hdr_count  = HdrMark;
          bytes_left = len_q;
          if (len_q == 16'd0) t.last = 1'b1;
          else in_payload = 1'b1;
        end
      endcase
    end
    t.data = b;
    t.chan = chan_q;
    t.seq  = seq_q;
    t.len  = len_q;
    return t;
  endfunction

  // Sends one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!no_stalls && $urandom_range(99) < 29) begin
      rx_if.valid   = 1'b0;
      rx_if.rx_byte = 8'($urandom);
      @(negedge clk_i);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk_i); while (!rx_if.ready);
    pending_tags.push_back(deframe_byte(b));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [7:0] chan, input logic [15:0] seq,
                             input logic [15:0] len);
    send_byte(StartMark);
    send_byte(chan);
    send_byte(seq[15:8]);
    send_byte(seq[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // Finishes whatever frame is open so the next header lands on a boundary
  task automatic resync();
    while (in_payload || hdr_count != HdrMark) begin
      if (!in_payload && hdr_count == HdrLenHi) send_byte(8'h00);
      else if (!in_payload && hdr_count == HdrLast) send_byte(8'($urandom_range(0, 6)));
      else send_byte(8'($urandom));
    end
  endtask

  task automatic send_frame();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(0, 8);
    else if (r < 97) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 300);
    resync();
    send_header(8'($urandom), 16'($urandom), 16'(len));
    repeat (len) send_byte(8'($urandom));
  endtask

  // Mostly well-formed frames, with noise bytes and cut-off headers mixed in
  task automatic run_stream(input int unsigned count);
    int unsigned stop_at;
    int unsigned r;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_byte(8'($urandom));
      end else if (r < 20) begin
        resync();
        send_byte(StartMark);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
      end else begin
        send_frame();
      end
    end
  endtask

  task automatic test_directed();
    // bad markers at both ends of the byte range
    send_byte(8'h00);
    send_byte(8'hff);
    // zero-length frame with all-ones channel and sequence fields
    send_header(8'hff, 16'hffff, 16'h0000);
    // payload carrying the extremes and a byte equal to the marker
    send_header(8'h00, 16'h0000, 16'h0003);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(StartMark);
    // single payload byte
    send_header(8'h5a, 16'h8001, 16'h0001);
    send_byte(8'h80);
    // bad marker after a frame shows the held header values
    send_byte(8'h2b);
  endtask

  task automatic test_random_stream();
    run_stream(580);
  endtask

  // Sender holds off until every byte sent so far has come back
  task automatic test_drain_pause();
    run_stream(60);
    rx_if.valid = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    run_stream(60);
  endtask

  task automatic test_no_stalls();
    no_stalls = 1'b1;
    run_stream(130);
    no_stalls = 1'b0;
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    tag_if.ready <= no_stalls ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // Result checker
  always @(posedge clk_i) begin
    byte_tag_t exp_t;
    if (rst_ni && tag_if.valid && tag_if.ready) begin
      if (pending_tags.size() == 0) begin
        $error("unexpected result item: byte_out %02h", tag_if.byte_out);
        mismatches++;
      end else begin
        exp_t = pending_tags.pop_front();
        if (tag_if.kind !== exp_t.kind) begin
          $error("kind: expected %0d, got %0d", exp_t.kind, tag_if.kind);
          mismatches++;
        end
        if (tag_if.byte_out !== exp_t.data) begin
          $error("byte_out: expected %02h, got %02h", exp_t.data, tag_if.byte_out);
          mismatches++;
        end
        if (tag_if.channel !== exp_t.chan) begin
          $error("channel: expected %02h, got %02h", exp_t.chan, tag_if.channel);
          mismatches++;
        end
        if (tag_if.sequence_res !== exp_t.seq) begin
          $error("sequence_res: expected %04h, got %04h", exp_t.seq, tag_if.sequence_res);
          mismatches++;
        end
        if (tag_if.payload_length !== exp_t.len) begin
          $error("payload_length: expected %04h, got %04h", exp_t.len,
                 tag_if.payload_length);
          mismatches++;
        end
        if (tag_if.frame_end !== exp_t.last) begin
          $error("frame_end: expected %0b, got %0b", exp_t.last, tag_if.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    tag_if.ready  = 1'b0;
    no_stalls     = 1'b0;
    bytes_sent    = 0;
    mismatches    = 0;
    in_payload    = 1'b0;
    hdr_count     = HdrMark;
    chan_q        = '0;
    seq_q         = '0;
    len_q         = '0;
    bytes_left    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_stream();
    test_drain_pause();
    test_no_stalls();

    rx_if.valid = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- flap_frame_deframer_core.f -----
hdl/fdf_pkg.sv
hdl/fdf_if.sv
hdl/flap_frame_deframer_core.sv
dv/testbench.sv
